// ===== rtl/gest_pkg.sv =====
// shared types and constants for the gamepad event state tracker
// used by gest_div, gamepad_event_state_tracker and its testbench
package gest_pkg;

  localparam int unsigned MAX_BUTTONS_DEF = 64;
  localparam int unsigned MAX_AXES_DEF    = 8;
  localparam int unsigned MAX_HATS_DEF    = 4;
  localparam int unsigned KEY_CODES_DEF   = 768;
  localparam int unsigned ABS_CODES_DEF   = 64;

  // request codes
  localparam logic [1:0] REQ_EVENT   = 2'd0;
  localparam logic [1:0] REQ_POLL    = 2'd1;
  localparam logic [1:0] REQ_KEY_MAP = 2'd2;
  localparam logic [1:0] REQ_ABS_MAP = 2'd3;

  // raw event types
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_ABS = 16'd3;

  // absolute codes that drive hats, x half on even codes
  localparam logic [15:0] HAT_CODE_FIRST = 16'd16;
  localparam logic [15:0] HAT_CODE_LAST  = 16'd23;

  // changed kind codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_AXIS   = 2'd2;
  localparam logic [1:0] KIND_HAT    = 2'd3;

  // hat half sign codes
  localparam logic [1:0] SGN_ZERO  = 2'd0;
  localparam logic [1:0] SGN_PLUS  = 2'd1;
  localparam logic [1:0] SGN_MINUS = 2'd3;

  // axis scaling in q2.14
  localparam logic signed [15:0] Q_ONE = 16'sd16384;
  localparam int unsigned Q_BITS = 15;
  localparam int unsigned NUM_W  = 34;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned SPAN_W = 33;
  localparam int unsigned DIFF_W = 35;

  typedef struct packed {
    logic       vld;
    logic [5:0] idx;
  } map_entry_t;

  localparam int unsigned MAP_W = $bits(map_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECODE,
    ST_SPAN,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/gest_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module gest_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gest_div.sv =====
// restoring divider for axis scaling, one quotient bit per cycle
// depends on gest_pkg; numerator is below twice the divisor
module gest_div import gest_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [Q_BITS-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(Q_BITS);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [Q_BITS-1:0] quot_q;
  logic              ge;
  logic [NUM_W-1:0]  rem_sel;

  always_comb begin
    ge      = rem_q >= NUM_W'(den_q);
    rem_sel = ge ? (rem_q - NUM_W'(den_q)) : rem_q;
    rem_d   = {rem_sel[NUM_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(Q_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[Q_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0) |=> (done_o && !busy_q))
    else $error("divider did not finish after last step");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("divider done held longer than one cycle");
`endif

endmodule

// ===== rtl/gamepad_event_state_tracker.sv =====
// gamepad event state tracker: follows buttons, axes and hats of one pad
// depends on gest_pkg, gest_ram and gest_div
//
// input channel: in_valid_i / in_stall_o with one item per beat; an item is
// an event, a poll boundary or a key or absolute map write. output channel:
// out_valid_o / out_stall_i, exactly one result beat per item.
// after reset the key and absolute maps are swept to unmapped, one entry a
// cycle over max(KEY_CODES, ABS_CODES) entries; in_stall_o stays high
// during the sweep.
// items are handled one at a time by a small sequencer: lookup, decode and
// finish for map writes, polls, key and hat events. axis events add span and
// prep and run a shared restoring divider, one quotient bit a cycle over 15
// bits; a zero or negative range or a saturated level skips the divider.
// the result sits in an output register, so a new item is taken while the
// previous result waits; if the receiver still stalls when the next result
// is ready, the sequencer holds that result and keeps in_stall_o high.
module gamepad_event_state_tracker import gest_pkg::*; #(
  parameter int unsigned MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int unsigned MAX_AXES    = MAX_AXES_DEF,
  parameter int unsigned MAX_HATS    = MAX_HATS_DEF,
  parameter int unsigned KEY_CODES   = KEY_CODES_DEF,
  parameter int unsigned ABS_CODES   = ABS_CODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        event_type_i,
  input  logic [15:0]        event_code_i,
  input  logic signed [31:0] event_value_i,
  input  logic               map_valid_i,
  input  logic [5:0]         map_index_i,
  input  logic signed [31:0] axis_low_i,
  input  logic signed [31:0] axis_high_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        buttons_down_o,
  output logic [63:0]        buttons_pressed_o,
  output logic [1:0]         changed_kind_o,
  output logic [5:0]         changed_index_o,
  output logic signed [15:0] axis_level_o,
  output logic [3:0]         hat_dirs_o,
  output logic [3:0]         hat_new_dirs_o
);

  localparam int unsigned KAW   = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
  localparam int unsigned AAW   = $clog2(ABS_CODES);
  localparam int unsigned AXW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int unsigned HW    = (MAX_HATS > 1) ? $clog2(MAX_HATS) : 1;
  localparam int unsigned CLR_N = (KEY_CODES > ABS_CODES) ? KEY_CODES : ABS_CODES;
  localparam int unsigned CLW   = $clog2(CLR_N + 1);

  function automatic logic [1:0] sign_code(logic signed [31:0] v);
    logic [1:0] s;
    if (v < 0) begin
      s = SGN_MINUS;
    end else if (v > 0) begin
      s = SGN_PLUS;
    end else begin
      s = SGN_ZERO;
    end
    return s;
  endfunction

  state_e state_q, state_d;
  logic [CLW-1:0] clr_q;

  // captured item
  logic [1:0]         req_q;
  logic [15:0]        etype_q;
  logic [15:0]        code_q;
  logic signed [31:0] value_q;
  logic               mvalid_q;
  logic [5:0]         midx_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;

  // result being built
  logic [1:0]         kind_q;
  logic [5:0]         which_q;
  logic signed [15:0] level_q;
  logic [3:0]         hd_q;
  logic [3:0]         hn_q;

  // pad state
  logic [MAX_BUTTONS-1:0] down_q;
  logic [MAX_BUTTONS-1:0] press_q;
  logic [3:0]             hat_ax_q  [MAX_HATS];
  logic [3:0]             hat_now_q [MAX_HATS];
  logic [3:0]             hat_new_q [MAX_HATS];

  // axis arithmetic
  logic signed [SPAN_W-1:0] span_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic                     neg_q;

  // output register
  logic               out_valid_q;
  logic [63:0]        o_down_q;
  logic [63:0]        o_press_q;
  logic [1:0]         o_kind_q;
  logic [5:0]         o_which_q;
  logic signed [15:0] o_level_q;
  logic [3:0]         o_hd_q;
  logic [3:0]         o_hn_q;

  // memories
  logic             key_we, abs_we, bnd_we;
  logic [KAW-1:0]   key_waddr;
  logic [AAW-1:0]   abs_waddr;
  map_entry_t       key_wdata, abs_wdata;
  logic [MAP_W-1:0] key_rd_raw, abs_rd_raw;
  map_entry_t       key_rd, abs_rd;
  logic [63:0]      bnd_rd;
  logic signed [31:0] bnd_lo, bnd_hi;

  // divider
  logic              div_start;
  logic              div_done;
  logic [Q_BITS-1:0] div_quot;

  // decode
  logic                   key_in_range, abs_in_range, is_hat_code;
  logic                   key_hit, abs_ev, hat_hit, axis_hit, axis_map_ok;
  logic [MAX_BUTTONS-1:0] btn_bit;
  logic [HW-1:0]          hn_idx;
  logic [1:0]             sc;
  logic [3:0]             ax_old, ax_new, dirs, new_n;
  logic                   span_pos, sat, out_load;
  logic [NUM_W-1:0]       mag;
  logic [NUM_W-1:0]       two_span;
  logic [Q_BITS-1:0]      qsat;
  logic signed [15:0]     div_level;

  assign key_rd = map_entry_t'(key_rd_raw);
  assign abs_rd = map_entry_t'(abs_rd_raw);
  assign bnd_lo = bnd_rd[31:0];
  assign bnd_hi = bnd_rd[63:32];

  gest_ram #(
    .WIDTH (MAP_W),
    .DEPTH (KEY_CODES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (code_q[KAW-1:0]),
    .rdata_o (key_rd_raw)
  );

  gest_ram #(
    .WIDTH (MAP_W),
    .DEPTH (ABS_CODES)
  ) u_abs_ram (
    .clk_i   (clk_i),
    .we_i    (abs_we),
    .waddr_i (abs_waddr),
    .wdata_i (abs_wdata),
    .raddr_i (code_q[AAW-1:0]),
    .rdata_o (abs_rd_raw)
  );

  // axis bounds, high in the upper half
  gest_ram #(
    .WIDTH (64),
    .DEPTH (MAX_AXES)
  ) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (midx_q[AXW-1:0]),
    .wdata_i ({hi_q, lo_q}),
    .raddr_i (abs_rd.idx[AXW-1:0]),
    .rdata_o (bnd_rd)
  );

  gest_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag),
    .den_i   (span_q[DEN_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    key_in_range = code_q < 16'(KEY_CODES);
    abs_in_range = code_q < 16'(ABS_CODES);
    is_hat_code  = (code_q >= HAT_CODE_FIRST) && (code_q <= HAT_CODE_LAST);

    key_hit = (req_q == REQ_EVENT) && (etype_q == EV_KEY) && key_in_range
              && key_rd.vld && ({1'b0, key_rd.idx} < 7'(MAX_BUTTONS));
    abs_ev  = (req_q == REQ_EVENT) && (etype_q == EV_ABS) && abs_in_range && abs_rd.vld;
    hat_hit  = abs_ev && is_hat_code && ({1'b0, abs_rd.idx} < 7'(MAX_HATS));
    axis_hit = abs_ev && !is_hat_code && ({1'b0, abs_rd.idx} < 7'(MAX_AXES));
    axis_map_ok = mvalid_q && !is_hat_code && ({1'b0, midx_q} < 7'(MAX_AXES));

    btn_bit = MAX_BUTTONS'(1) << key_rd.idx;

    // hat rebuild: y minus is up, y plus is down, x minus left, x plus right
    hn_idx = abs_rd.idx[HW-1:0];
    sc     = sign_code(value_q);
    ax_old = hat_ax_q[hn_idx];
    ax_new = code_q[0] ? {sc, ax_old[1:0]} : {ax_old[3:2], sc};
    dirs   = {ax_new[1:0] == SGN_PLUS, ax_new[1:0] == SGN_MINUS,
              ax_new[3:2] == SGN_PLUS, ax_new[3:2] == SGN_MINUS};
    new_n  = hat_new_q[hn_idx] | (dirs & ~hat_now_q[hn_idx]);

    // magnitude of 2*value - low - high against twice the span
    span_pos = !span_q[SPAN_W-1] && (span_q != '0);
    mag      = diff_q[DIFF_W-1] ? NUM_W'(-diff_q) : NUM_W'(diff_q);
    two_span = {1'b0, span_q[DEN_W-1:0], 1'b0};
    sat      = mag >= two_span;

    qsat      = (div_quot > Q_BITS'(Q_ONE)) ? Q_BITS'(Q_ONE) : div_quot;
    div_level = neg_q ? -{1'b0, qsat} : {1'b0, qsat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    key_we    = 1'b0;
    key_waddr = code_q[KAW-1:0];
    key_wdata = '{vld: mvalid_q, idx: midx_q};
    abs_we    = 1'b0;
    abs_waddr = code_q[AAW-1:0];
    abs_wdata = '{vld: mvalid_q, idx: midx_q};
    bnd_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        key_we    = clr_q < CLW'(KEY_CODES);
        key_waddr = clr_q[KAW-1:0];
        key_wdata = '0;
        abs_we    = clr_q < CLW'(ABS_CODES);
        abs_waddr = clr_q[AAW-1:0];
        abs_wdata = '0;
        if (clr_q == CLW'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        key_we  = (req_q == REQ_KEY_MAP) && key_in_range;
        abs_we  = (req_q == REQ_ABS_MAP) && abs_in_range;
        bnd_we  = (req_q == REQ_ABS_MAP) && abs_in_range && axis_map_ok;
        state_d = axis_hit ? ST_SPAN : ST_FINISH;
      end
      ST_SPAN: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        if (span_pos && !sat) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      down_q      <= '0;
      press_q     <= '0;
      out_valid_q <= 1'b0;
      for (int h = 0; h < MAX_HATS; h++) begin
        hat_ax_q[h]  <= '0;
        hat_now_q[h] <= '0;
        hat_new_q[h] <= '0;
      end
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_DECODE) begin
        if (req_q == REQ_POLL) begin
          press_q <= '0;
          for (int h = 0; h < MAX_HATS; h++) begin
            hat_new_q[h] <= '0;
          end
        end
        if (key_hit) begin
          if (value_q != '0) begin
            press_q <= press_q | (btn_bit & ~down_q);
            down_q  <= down_q | btn_bit;
          end else begin
            down_q <= down_q & ~btn_bit;
          end
        end
        if (hat_hit) begin
          hat_ax_q[hn_idx]  <= ax_new;
          hat_now_q[hn_idx] <= dirs;
          hat_new_q[hn_idx] <= new_n;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q    <= req_type_i;
      etype_q  <= event_type_i;
      code_q   <= event_code_i;
      value_q  <= event_value_i;
      mvalid_q <= map_valid_i;
      midx_q   <= map_index_i;
      lo_q     <= axis_low_i;
      hi_q     <= axis_high_i;
      kind_q   <= KIND_NONE;
      which_q  <= '0;
      level_q  <= '0;
      hd_q     <= '0;
      hn_q     <= '0;
    end
    if (state_q == ST_DECODE) begin
      if (key_hit) begin
        kind_q  <= KIND_BUTTON;
        which_q <= key_rd.idx;
      end
      if (hat_hit) begin
        kind_q  <= KIND_HAT;
        which_q <= abs_rd.idx;
        hd_q    <= dirs;
        hn_q    <= new_n;
      end
      if (axis_hit) begin
        kind_q  <= KIND_AXIS;
        which_q <= abs_rd.idx;
      end
    end
    if (state_q == ST_SPAN) begin
      span_q <= {bnd_hi[31], bnd_hi} - {bnd_lo[31], bnd_lo};
      diff_q <= {{2{value_q[31]}}, value_q, 1'b0}
                - {{3{bnd_lo[31]}}, bnd_lo} - {{3{bnd_hi[31]}}, bnd_hi};
    end
    if (state_q == ST_PREP) begin
      neg_q <= diff_q[DIFF_W-1];
      if (!span_pos) begin
        level_q <= '0;
      end else if (sat) begin
        level_q <= diff_q[DIFF_W-1] ? -Q_ONE : Q_ONE;
      end
    end
    if (state_q == ST_DIV && div_done) begin
      level_q <= div_level;
    end
    if (out_load) begin
      o_down_q  <= 64'(down_q);
      o_press_q <= 64'(press_q);
      o_kind_q  <= kind_q;
      o_which_q <= which_q;
      o_level_q <= level_q;
      o_hd_q    <= hd_q;
      o_hn_q    <= hn_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign buttons_down_o    = o_down_q;
  assign buttons_pressed_o = o_press_q;
  assign changed_kind_o    = o_kind_q;
  assign changed_index_o   = o_which_q;
  assign axis_level_o      = o_level_q;
  assign hat_dirs_o        = o_hd_q;
  assign hat_new_dirs_o    = o_hn_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_LOOKUP))
    else $error("accepted beat did not start the lookup");

  a_no_reclear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
    else $error("map sweep restarted outside reset");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((axis_level_o <= Q_ONE) && (axis_level_o >= -Q_ONE)))
    else $error("axis level outside -1..+1");

  a_level_only_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (changed_kind_o != KIND_AXIS)) |-> (axis_level_o == '0))
    else $error("axis level set on a non-axis result");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (changed_kind_o == KIND_NONE))
      |-> ((changed_index_o == '0) && (hat_dirs_o == '0) && (hat_new_dirs_o == '0)))
    else $error("ignored item reports index or hat bits");
`endif

endmodule

// ===== sim/gamepad_event_state_tracker_tb.sv =====
// self-checking testbench for gamepad_event_state_tracker
// needs gest_pkg and the tracker rtl; drives valid/stall beats, predicts every report
`timescale 1ns / 1ps

module gamepad_event_state_tracker_tb;
  import gest_pkg::*;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] etype;
    logic [15:0] code;
    logic [31:0] value;
    logic        mvalid;
    logic [5:0]  midx;
    logic [31:0] lo;
    logic [31:0] hi;
  } pad_item_t;

  typedef struct packed {
    logic [63:0] down;
    logic [63:0] pressed;
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [15:0] level;
    logic [3:0]  hd;
    logic [3:0]  hn;
  } pad_report_t;

  typedef struct packed {
    pad_item_t   item;
    logic        typed;
    pad_report_t want;
  } dir_row_t;

  localparam pad_report_t NO_CHANGE = '0;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic [15:0]        event_type_i;
  logic [15:0]        event_code_i;
  logic signed [31:0] event_value_i;
  logic               map_valid_i;
  logic [5:0]         map_index_i;
  logic signed [31:0] axis_low_i;
  logic signed [31:0] axis_high_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [63:0]        buttons_down_o;
  logic [63:0]        buttons_pressed_o;
  logic [1:0]         changed_kind_o;
  logic [5:0]         changed_index_o;
  logic signed [15:0] axis_level_o;
  logic [3:0]         hat_dirs_o;
  logic [3:0]         hat_new_dirs_o;

  gamepad_event_state_tracker i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .event_type_i,
    .event_code_i,
    .event_value_i,
    .map_valid_i,
    .map_index_i,
    .axis_low_i,
    .axis_high_i,
    .out_valid_o,
    .out_stall_i,
    .buttons_down_o,
    .buttons_pressed_o,
    .changed_kind_o,
    .changed_index_o,
    .axis_level_o,
    .hat_dirs_o,
    .hat_new_dirs_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  map_entry_t         key_slot [KEY_CODES_DEF];
  map_entry_t         abs_slot [ABS_CODES_DEF];
  logic signed [31:0] ax_min [MAX_AXES_DEF];
  logic signed [31:0] ax_max [MAX_AXES_DEF];
  logic signed [15:0] ax_level [MAX_AXES_DEF];
  logic [63:0]        held;
  logic [63:0]        fresh;
  logic [3:0]         hat_sgn [MAX_HATS_DEF];
  logic [3:0]         hat_cur [MAX_HATS_DEF];
  logic [3:0]         hat_fresh [MAX_HATS_DEF];

  pad_report_t pending_reports [$];
  dir_row_t    dir_rows [$];
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic bit in_hat_range(input logic [15:0] code);
    return code >= HAT_CODE_FIRST && code <= HAT_CODE_LAST;
  endfunction

  function automatic pad_item_t mk_item(input logic [1:0] req, input logic [15:0] etype,
                                        input logic [15:0] code, input logic [31:0] value,
                                        input logic mv, input logic [5:0] midx,
                                        input logic [31:0] lo, input logic [31:0] hi);
    return '{req, etype, code, value, mv, midx, lo, hi};
  endfunction

  function automatic string fmt_report(input pad_report_t r);
    return $sformatf("down %h pressed %h kind %0d idx %0d level %0d hat %h new %h",
                     r.down, r.pressed, r.kind, r.index, $signed(r.level), r.hd, r.hn);
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < 10) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // applies one item to the predicted pad state and returns the report it causes
  function automatic pad_report_t track_gamepad(input pad_item_t it);
    pad_report_t        r;
    map_entry_t         ent;
    logic signed [31:0] v;
    longint             span, num, q;
    logic [63:0]        bit_m;
    logic [3:0]         sg, dirs;
    logic [1:0]         sgn;
    r = '0;
    v = it.value;
    ent = '{vld: it.mvalid, idx: it.midx};
    case (it.req)
      REQ_POLL: begin
        fresh = '0;
        hat_fresh = '{default: '0};
      end
      REQ_KEY_MAP: begin
        if (it.code < KEY_CODES_DEF) key_slot[it.code] = ent;
      end
      REQ_ABS_MAP: begin
        if (it.code < ABS_CODES_DEF) begin
          abs_slot[it.code] = ent;
          if (it.mvalid && !in_hat_range(it.code) && it.midx < MAX_AXES_DEF) begin
            ax_min[it.midx] = it.lo;
            ax_max[it.midx] = it.hi;
          end
        end
      end
      default: begin
        if (it.etype == EV_KEY && it.code < KEY_CODES_DEF) begin
          ent = key_slot[it.code];
          if (ent.vld && ent.idx < MAX_BUTTONS_DEF) begin
            bit_m = 64'd1 << ent.idx;
            if (v != 0) begin
              fresh = fresh | (bit_m & ~held);
              held  = held | bit_m;
            end else begin
              held = held & ~bit_m;
            end
            r.kind  = KIND_BUTTON;
            r.index = ent.idx;
          end
        end else if (it.etype == EV_ABS && it.code < ABS_CODES_DEF) begin
          ent = abs_slot[it.code];
          sgn = (v < 0) ? SGN_MINUS : ((v > 0) ? SGN_PLUS : SGN_ZERO);
          if (ent.vld && in_hat_range(it.code)) begin
            if (ent.idx < MAX_HATS_DEF) begin
              sg = hat_sgn[ent.idx];
              // even codes carry the x half
              if (!it.code[0]) sg[1:0] = sgn;
              else sg[3:2] = sgn;
              hat_sgn[ent.idx] = sg;
              dirs[0] = (sg[3:2] == SGN_MINUS);
              dirs[1] = (sg[3:2] == SGN_PLUS);
              dirs[2] = (sg[1:0] == SGN_MINUS);
              dirs[3] = (sg[1:0] == SGN_PLUS);
              hat_fresh[ent.idx] = hat_fresh[ent.idx] | (dirs & ~hat_cur[ent.idx]);
              hat_cur[ent.idx] = dirs;
              r.kind  = KIND_HAT;
              r.index = ent.idx;
              r.hd    = dirs;
              r.hn    = hat_fresh[ent.idx];
            end
          end else if (ent.vld && ent.idx < MAX_AXES_DEF) begin
            span = longint'(ax_max[ent.idx]) - longint'(ax_min[ent.idx]);
            if (span <= 0) begin
              q = 0;
            end else begin
              num = (2 * (longint'(v) - longint'(ax_min[ent.idx])) - span) * longint'(Q_ONE);
              q = num / span;
              if (q > longint'(Q_ONE)) q = longint'(Q_ONE);
              if (q < -longint'(Q_ONE)) q = -longint'(Q_ONE);
            end
            ax_level[ent.idx] = 16'(q);
            r.kind  = KIND_AXIS;
            r.index = ent.idx;
            r.level = 16'(q);
          end
        end
      end
    endcase
    r.down    = held;
    r.pressed = fresh;
    return r;
  endfunction

  function automatic logic [15:0] pick_key_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 16'($urandom_range(0, 15));
    if (roll < 90) return 16'($urandom_range(752, 767));
    return 16'($urandom);
  endfunction

  // mostly well-formed map writes and events on a small set of codes, some noise
  function automatic pad_item_t pick_stimulus();
    pad_item_t   it;
    int unsigned roll, sub;
    it = '{2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), $urandom,
           1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      it.req    = REQ_KEY_MAP;
      it.code   = pick_key_code();
      it.mvalid = ($urandom_range(0, 99) < 85);
    end else if (roll < 16) begin
      it.req    = REQ_ABS_MAP;
      it.mvalid = ($urandom_range(0, 99) < 85);
      sub = $urandom_range(0, 99);
      if (sub < 40) begin
        it.code = 16'($urandom_range(16, 23));
        it.midx = 6'($urandom_range(0, 4));
      end else if (sub < 95) begin
        it.code = 16'($urandom_range(0, 63));
        it.midx = 6'($urandom_range(0, 8));
      end
      sub = $urandom_range(0, 9);
      if (sub < 6) begin
        it.lo = -32'($urandom_range(0, 40000));
        it.hi = 32'($urandom_range(0, 40000));
      end else if (sub == 6) begin
        it.hi = it.lo;
      end else if (sub == 7) begin
        it.lo = 32'($urandom_range(1, 40000));
        it.hi = -32'($urandom_range(0, 40000));
      end
    end else if (roll < 23) begin
      it.req = REQ_POLL;
    end else if (roll < 58) begin
      it.req   = REQ_EVENT;
      it.etype = EV_KEY;
      it.code  = pick_key_code();
      sub = $urandom_range(0, 99);
      if (sub < 45) it.value = 32'd1;
      else if (sub < 85) it.value = 32'd0;
    end else if (roll < 82) begin
      it.req   = REQ_EVENT;
      it.etype = EV_ABS;
      if ($urandom_range(0, 9) != 0) it.code = 16'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 65) it.value = 32'($urandom_range(0, 80000)) - 32'd40000;
    end else if (roll < 95) begin
      it.req   = REQ_EVENT;
      it.etype = EV_ABS;
      it.code  = 16'($urandom_range(16, 23));
      if ($urandom_range(0, 99) < 70) it.value = 32'($urandom_range(0, 2)) - 32'd1;
    end
    return it;
  endfunction

  // entered at a falling edge, returns at the falling edge after the beat is taken
  task automatic offer_beat(input pad_item_t it, input logic typed, input pad_report_t want,
                            output bit effect);
    pad_report_t guess;
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= it.req;
    event_type_i  <= it.etype;
    event_code_i  <= it.code;
    event_value_i <= it.value;
    map_valid_i   <= it.mvalid;
    map_index_i   <= it.midx;
    axis_low_i    <= it.lo;
    axis_high_i   <= it.hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    guess = track_gamepad(it);
    pending_reports.push_back(typed ? want : guess);
    effect = (it.req != REQ_EVENT) || (guess.kind != KIND_NONE);
    @(negedge clk_i);
  endtask

  // receiver: random stall, one long hold-off on request
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (!calm && $urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk_i) begin : report_check
    pad_report_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{buttons_down_o, buttons_pressed_o, changed_kind_o, changed_index_o,
              axis_level_o, hat_dirs_o, hat_new_dirs_o};
      if (pending_reports.size() == 0) begin
        flag_error({"unexpected report: ", fmt_report(got)});
      end else begin
        want = pending_reports.pop_front();
        if (got.down !== want.down || got.pressed !== want.pressed ||
            got.kind !== want.kind || got.index !== want.index ||
            got.level !== want.level || got.hd !== want.hd || got.hn !== want.hn)
          flag_error($sformatf("report %0d\n  expected %s\n  actual   %s",
                               reports_seen, fmt_report(want), fmt_report(got)));
      end
      reports_seen++;
    end
  end

  initial begin : stim
    bit          effect, hold_given;
    int unsigned counted, waited;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_POLL;
    event_type_i  = '0;
    event_code_i  = '0;
    event_value_i = '0;
    map_valid_i   = 1'b0;
    map_index_i   = '0;
    axis_low_i    = '0;
    axis_high_i   = '0;
    rst_ni        = 1'b0;
    key_slot  = '{default: '0};
    abs_slot  = '{default: '0};
    ax_min    = '{default: '0};
    ax_max    = '{default: '0};
    ax_level  = '{default: '0};
    held      = '0;
    fresh     = '0;
    hat_sgn   = '{default: '0};
    hat_cur   = '{default: '0};
    hat_fresh = '{default: '0};
    hold_given = 1'b0;
    counted    = 0;
    waited     = 0;

    // reset state, unmapped codes, table extremes, out-of-table codes
    dir_rows.push_back('{mk_item(REQ_POLL, 16'd0, 16'd0, 32'd0, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b1, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_KEY, 16'd5, 32'd1, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b1, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_KEY_MAP, 16'd0, 16'd5, 32'd0, 1'b1, 6'd0, 32'd0, 32'd0),
                         1'b1, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_KEY_MAP, 16'd0, 16'd767, 32'd0, 1'b1, 6'd63, 32'd0,
                                 32'd0), 1'b1, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_KEY_MAP, 16'd0, 16'd768, 32'd0, 1'b1, 6'd1, 32'd0,
                                 32'd0), 1'b1, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_KEY, 16'd5, 32'd1, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b1, '{64'h1, 64'h1, KIND_BUTTON, 6'd0, 16'd0, 4'd0, 4'd0}});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_KEY, 16'd767, 32'h8000_0000, 1'b0, 6'd0, 32'd0,
                                 32'd0), 1'b1,
                         '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, KIND_BUTTON,
                           6'd63, 16'd0, 4'd0, 4'd0}});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_KEY, 16'hffff, 32'd1, 1'b1, 6'd0, 32'd0, 32'd0),
                         1'b1, '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, KIND_NONE,
                                 6'd0, 16'd0, 4'd0, 4'd0}});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_KEY, 16'd5, 32'd0, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_POLL, 16'd0, 16'd0, 32'd0, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    // axes: full scale, saturation, zero span, index past the axis count
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd0, 32'd0, 1'b1, 6'd0, -32'sd32768,
                                 32'sd32767), 1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd0, -32'sd32768, 1'b0, 6'd0, 32'd0,
                                 32'd0), 1'b1,
                         '{64'h8000_0000_0000_0000, 64'h0, KIND_AXIS, 6'd0, -Q_ONE, 4'd0,
                           4'd0}});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd0, 32'h7fff_ffff, 1'b0, 6'd0, 32'd0,
                                 32'd0), 1'b1,
                         '{64'h8000_0000_0000_0000, 64'h0, KIND_AXIS, 6'd0, Q_ONE, 4'd0,
                           4'd0}});
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd63, 32'd0, 1'b1, 6'd7, 32'h8000_0000,
                                 32'h7fff_ffff), 1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd63, 32'd0, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd1, 32'd0, 1'b1, 6'd1, 32'd5, 32'd5),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd1, 32'd99, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b1, '{64'h8000_0000_0000_0000, 64'h0, KIND_AXIS, 6'd1, 16'd0, 4'd0,
                                 4'd0}});
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd2, 32'd0, 1'b1, 6'd8, 32'd0, 32'd9),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd2, 32'd3, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b1, '{64'h8000_0000_0000_0000, 64'h0, KIND_NONE, 6'd0, 16'd0, 4'd0,
                                 4'd0}});
    // hats: both halves of one hat, then a hat number past the hat count
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd16, 32'd0, 1'b1, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd17, 32'd0, 1'b1, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd16, -32'sd1, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd17, 32'd7, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd23, 32'd0, 1'b1, 6'd5, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd23, 32'd1, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    // other event type, absolute code past the table, unmapping
    dir_rows.push_back('{mk_item(REQ_EVENT, 16'hffff, 16'd0, 32'd1, 1'b1, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd64, 32'd1, 1'b1, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_ABS_MAP, 16'd0, 16'd0, 32'd0, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});
    dir_rows.push_back('{mk_item(REQ_EVENT, EV_ABS, 16'd0, 32'd1, 1'b0, 6'd0, 32'd0, 32'd0),
                         1'b0, NO_CHANGE});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the map sweep after reset holds in_stall_o, the first beat just waits for it
    foreach (dir_rows[i]) offer_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want,
                                     effect);

    while (counted < RANDOM_ITEMS) begin
      if (counted == 300 && !hold_given) begin
        hold_req   = 1'b1;
        hold_given = 1'b1;
      end
      calm = (counted >= 600 && counted < 800);
      offer_beat(pick_stimulus(), 1'b0, NO_CHANGE, effect);
      if (effect) counted++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending_reports.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_reports.size() != 0)
      flag_error($sformatf("%0d expected reports never arrived", pending_reports.size()));

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
